@@ src/fcp_pkg.sv @@
// ----------------------------------------------------------------------------
// fcp_pkg: shared types and constants of the framed command parser
// Byte codes, result kinds, the result record and frame limits.
// ----------------------------------------------------------------------------
package fcp_pkg;

	localparam logic [7:0] DELIM_BYTE = 8'h23;
	localparam logic [7:0] SEP_BYTE = 8'h2C;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [15:0] VALUE_MAX = 16'hFFFF;

	// frame bytes allowed, opening delimiter counted
	localparam int MAX_FRAME_BYTES = 30;
	localparam int KEPT_PARAMS_DEF = 4;
	// parameter slots on the result channel
	localparam int OUT_PARAMS = 4;

	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_FRAME = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] command_byte;
		logic [4:0] param_count;
		logic [OUT_PARAMS-1:0][15:0] params;
	} result_t;

endpackage

@@ src/fcp_ifs.sv @@
// ----------------------------------------------------------------------------
// fcp_ifs: channel interfaces of the framed command parser
// Received byte channel and parsed result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcp_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcp_res_if;
	logic valid;
	logic ready;
	logic [1:0] result_kind;
	logic [7:0] command_byte;
	logic [4:0] param_count;
	logic [15:0] param_newest;
	logic [15:0] param_second;
	logic [15:0] param_third;
	logic [15:0] param_fourth;

	modport source (output valid, output result_kind, output command_byte,
		output param_count, output param_newest, output param_second,
		output param_third, output param_fourth, input ready);
	modport sink (input valid, input result_kind, input command_byte,
		input param_count, input param_newest, input param_second,
		input param_third, input param_fourth, output ready);
endinterface

@@ src/framed_ascii_command_parser.sv @@
// ----------------------------------------------------------------------------
// framed_ascii_command_parser: serial byte command and frame parser
// Turns received bytes into single-byte commands and #C,n,...# frames.
// ----------------------------------------------------------------------------
// path: a byte waits in the byte register, its result in the result register
// throughput: one byte per cycle, set by the single decode step between the
//   byte register and the result register; res stalls hold back rx only when
//   a byte that gives a result meets a full result register
// reset: arst_n clears both stage valids and all frame state at once
// ----------------------------------------------------------------------------
module framed_ascii_command_parser
	import fcp_pkg::*;
#(
	parameter int KEPT_PARAMS = KEPT_PARAMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fcp_rx_if.sink rx,
	fcp_res_if.source res
);

	// stage 1: received byte register
	logic valid_s1;
	logic [7:0] byte_s1;
	// stage 2: result register, parts the two sides
	logic valid_s2;
	result_t result_s2;

	logic has_result;
	result_t result;
	logic advance;

	// a byte that gives no result never waits on the result register
	assign advance = valid_s1 && (!has_result || !valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || advance;

	fcp_frame_state #(
		.KEPT_PARAMS(KEPT_PARAMS)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(advance),
		.rx_byte(byte_s1),
		.has_result(has_result),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance && has_result) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (advance && has_result) begin
			result_s2 <= result;
		end
	end

	assign res.valid = valid_s2;
	assign res.result_kind = result_s2.result_kind;
	assign res.command_byte = result_s2.command_byte;
	assign res.param_count = result_s2.param_count;
	assign res.param_newest = result_s2.params[0];
	assign res.param_second = result_s2.params[1];
	assign res.param_third = result_s2.params[2];
	assign res.param_fourth = result_s2.params[3];

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(byte_s1))
		else $error("stalled byte lost in stage 1");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> valid_s2 && !res.ready)
		else $error("stage 1 stalled without a blocked result");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result) |=> valid_s2)
		else $error("result not captured in stage 2");

endmodule

@@ src/fcp_frame_state.sv @@
// ----------------------------------------------------------------------------
// fcp_frame_state: frame tracking and parameter accumulation
// Holds the frame state, decodes one byte per step and forms its result.
// ----------------------------------------------------------------------------
module fcp_frame_state
	import fcp_pkg::*;
#(
	parameter int KEPT_PARAMS = KEPT_PARAMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  logic [7:0] rx_byte,
	output logic has_result,
	output result_t result
);

	logic in_frame_q;
	logic [4:0] frame_length_q;
	logic [7:0] frame_command_q;
	logic [15:0] segment_value_q;
	logic [4:0] comma_count_q;
	logic [15:0] hist_q [KEPT_PARAMS];
	logic [15:0] hist_shift [KEPT_PARAMS];

	logic [5:0] next_len;
	logic is_delim;
	logic is_sep;
	logic is_first;
	logic too_long;
	logic push;
	logic [7:0] digit;
	logic [19:0] seg_x10;
	logic [20:0] seg_sum;
	logic [15:0] seg_next;
	logic [7:0] cmd_eff;

	assign next_len = {1'b0, frame_length_q} + 6'd1;
	assign is_delim = (rx_byte == DELIM_BYTE);
	assign is_sep = (rx_byte == SEP_BYTE);
	assign is_first = (next_len == 6'd2);
	assign too_long = (next_len > 6'(MAX_FRAME_BYTES));
	// a separator or a non-empty close ends a parameter once a comma was seen
	assign push = in_frame_q && !too_long && (comma_count_q != 5'd0)
		&& (is_sep || (is_delim && !is_first));

	assign digit = rx_byte - DIGIT_BASE;
	assign seg_x10 = 20'(segment_value_q) * 20'd10;
	assign seg_sum = 21'(seg_x10) + 21'(digit);
	assign seg_next = (seg_sum > 21'(VALUE_MAX)) ? VALUE_MAX : seg_sum[15:0];
	assign cmd_eff = is_first ? rx_byte : frame_command_q;

	assign hist_shift[0] = push ? segment_value_q : hist_q[0];
	for (genvar i = 1; i < KEPT_PARAMS; i++) begin : g_shift
		assign hist_shift[i] = push ? hist_q[i-1] : hist_q[i];
	end

	always_comb begin
		has_result = 1'b0;
		result = '0;
		if (!in_frame_q) begin
			if (!is_delim) begin
				has_result = 1'b1;
				result.result_kind = KIND_SINGLE;
				result.command_byte = rx_byte;
			end
		end else if (too_long) begin
			has_result = 1'b1;
			result.result_kind = KIND_ERROR;
		end else if (is_delim) begin
			has_result = 1'b1;
			result.result_kind = KIND_FRAME;
			result.command_byte = cmd_eff;
			result.param_count = comma_count_q;
			for (int j = 0; j < OUT_PARAMS; j++) begin
				if (j < KEPT_PARAMS) begin
					result.params[j] = hist_shift[j % KEPT_PARAMS];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			frame_length_q <= '0;
			frame_command_q <= '0;
			segment_value_q <= '0;
			comma_count_q <= '0;
			for (int i = 0; i < KEPT_PARAMS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (step_en) begin
			if (!in_frame_q) begin
				if (is_delim) begin
					// frame start clears all frame data
					in_frame_q <= 1'b1;
					frame_length_q <= 5'd1;
					frame_command_q <= '0;
					segment_value_q <= '0;
					comma_count_q <= '0;
					for (int i = 0; i < KEPT_PARAMS; i++) begin
						hist_q[i] <= '0;
					end
				end
			end else if (too_long || is_delim) begin
				in_frame_q <= 1'b0;
				frame_length_q <= '0;
				hist_q <= hist_shift;
			end else begin
				frame_length_q <= next_len[4:0];
				if (is_first) begin
					frame_command_q <= rx_byte;
				end
				hist_q <= hist_shift;
				if (is_sep) begin
					segment_value_q <= '0;
					comma_count_q <= comma_count_q + 5'd1;
				end else begin
					segment_value_q <= seg_next;
				end
			end
		end
	end

	a_len_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> frame_length_q == 5'd0)
		else $error("length count not cleared outside a frame");
	a_len_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (frame_length_q != 5'd0)
			&& (frame_length_q <= 5'(MAX_FRAME_BYTES)))
		else $error("frame length out of range inside a frame");
	a_result_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && has_result) |=> !in_frame_q)
		else $error("a result left the parser inside a frame");
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		has_result |-> (result.result_kind == KIND_SINGLE)
			|| (result.result_kind == KIND_FRAME)
			|| (result.result_kind == KIND_ERROR))
		else $error("illegal result kind");

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the framed ascii command parser
// Drives received bytes through the rx channel and predicts each parsed
// result in a local model. Single bytes, special frames, frame length limits,
// then a long run of random frames, noise and broken frames. Both channels
// idle at random. Results are checked field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_top;
	import fcp_pkg::*;

	// idle chance in percent on each side while gaps are enabled
	localparam int IDLE_PCT = 30;
	// random bytes to send, the first ones with no idling at all
	localparam int RANDOM_BYTES = 600;
	localparam int CALM_BYTES = 150;
	// cycles with no item moving on either channel before giving up
	localparam int WATCHDOG_CYCLES = 4000;
	// a result passes the byte register and the result register, so a short settle
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;

	fcp_rx_if rx_ch ();
	fcp_res_if res_ch ();

	framed_ascii_command_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch)
	);

	// gaps_on enables random idling on both sides
	bit gaps_on;
	int mismatch_cnt;
	int bytes_sent;
	int stall_cycles;

	// parsed results still owed by the parser, oldest at the front
	result_t pending_cmds[$];

	// local copy of the parser state
	bit in_frm;
	int unsigned frm_len;
	logic [7:0] frm_cmd;
	int unsigned seg_val;
	logic [4:0] comma_cnt;
	logic [15:0] param_hist[KEPT_PARAMS_DEF];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// parser prediction
	// ------------------------------------------------------------------------

	// wipe everything a frame collects; done at reset and at every opening '#'
	function automatic void clear_frame();
		frm_cmd = '0;
		seg_val = 0;
		comma_cnt = '0;
		foreach (param_hist[i])
			param_hist[i] = '0;
	endfunction

	// newest parameter goes to slot 0, the oldest kept one falls off the end
	function automatic void shift_in_param(input int unsigned v);
		for (int i = KEPT_PARAMS_DEF - 1; i > 0; i--)
			param_hist[i] = param_hist[i-1];
		param_hist[0] = v[15:0];
	endfunction

	// advance the parser by one byte; has is set when the byte gives a result
	function automatic void parse_byte(input logic [7:0] b, output bit has,
			output result_t r);
		int unsigned nxt;
		int unsigned v;
		logic [7:0] d;
		r = '0;
		has = 1'b0;
		// outside a frame: '#' opens one, anything else is a command at once
		if (!in_frm) begin
			if (b != DELIM_BYTE) begin
				has = 1'b1;
				r.result_kind = KIND_SINGLE;
				r.command_byte = b;
			end else begin
				in_frm = 1'b1;
				frm_len = 1;
				clear_frame();
			end
			return;
		end
		// the byte that would push the frame past its limit is an error,
		// even a closing '#', and the frame is thrown away
		nxt = frm_len + 1;
		if (nxt > MAX_FRAME_BYTES) begin
			in_frm = 1'b0;
			frm_len = 0;
			has = 1'b1;
			r.result_kind = KIND_ERROR;
			return;
		end
		frm_len = nxt;
		if (b == DELIM_BYTE) begin
			// "##" is an empty frame whose command is '#' itself
			if (nxt == 2)
				frm_cmd = b;
			else if (comma_cnt != 0)
				shift_in_param(seg_val);
			has = 1'b1;
			r.result_kind = KIND_FRAME;
			r.command_byte = frm_cmd;
			r.param_count = comma_cnt;
			for (int j = 0; j < OUT_PARAMS; j++)
				r.params[j] = (j < KEPT_PARAMS_DEF) ? param_hist[j] : '0;
			in_frm = 1'b0;
			frm_len = 0;
			return;
		end
		if (nxt == 2)
			frm_cmd = b;
		// a ',' right after '#' is the command and also opens a parameter
		if (b == SEP_BYTE) begin
			if (comma_cnt != 0)
				shift_in_param(seg_val);
			seg_val = 0;
			comma_cnt = comma_cnt + 1'b1;
		end else begin
			// any byte is a digit, wrapped to 8 bits, value saturates
			d = b - DIGIT_BASE;
			v = seg_val * 10 + 32'(d);
			seg_val = (v > 32'(VALUE_MAX)) ? 32'(VALUE_MAX) : v;
		end
	endfunction

	// ------------------------------------------------------------------------
	// byte sender and result side
	// ------------------------------------------------------------------------

	// send one byte, with random idle cycles ahead of it while gaps are on;
	// the expectation is formed at the edge where the byte is taken
	task automatic send_byte(input logic [7:0] b);
		bit has;
		result_t r;
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		parse_byte(b, has, r);
		if (has)
			pending_cmds.push_back(r);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// compare each result taken from the parser with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch("unexpected result, kind", 16'(res_ch.result_kind), 16'd0);
			end else begin
				want = pending_cmds.pop_front();
				check_field("result_kind", 16'(res_ch.result_kind),
					16'(want.result_kind));
				check_field("command_byte", 16'(res_ch.command_byte),
					16'(want.command_byte));
				check_field("param_count", 16'(res_ch.param_count),
					16'(want.param_count));
				check_field("param_newest", res_ch.param_newest, want.params[0]);
				check_field("param_second", res_ch.param_second, want.params[1]);
				check_field("param_third", res_ch.param_third, want.params[2]);
				check_field("param_fourth", res_ch.param_fourth, want.params[3]);
			end
		end
	end

	// nothing moving on either channel for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// mostly a decimal digit, now and then any other byte that keeps the
	// frame shape intact
	function automatic logic [7:0] pick_digit();
		logic [7:0] b;
		if ($urandom_range(99) < 88)
			return DIGIT_BASE + 8'($urandom_range(9, 0));
		do
			b = 8'($urandom_range(255, 0));
		while (b == DELIM_BYTE || b == SEP_BYTE);
		return b;
	endfunction

	// #C,n,...# with random command, parameter count and digit counts
	task automatic send_random_frame();
		int n_params;
		int max_digits;
		int pick;
		logic [7:0] cmd;
		n_params = $urandom_range(6, 0);
		max_digits = ($urandom_range(99) < 15) ? 6 : 3;
		pick = $urandom_range(99);
		send_byte(DELIM_BYTE);
		if (pick < 8) begin
			// empty frame
			send_byte(DELIM_BYTE);
			return;
		end
		if (pick < 16) begin
			cmd = SEP_BYTE;
		end else begin
			do
				cmd = 8'($urandom_range(255, 0));
			while (cmd == DELIM_BYTE);
		end
		send_byte(cmd);
		for (int p = 0; p < n_params; p++) begin
			send_byte(SEP_BYTE);
			repeat ($urandom_range(max_digits, 0))
				send_byte(pick_digit());
		end
		send_byte(DELIM_BYTE);
	endtask

	// a frame near or past the length limit; the tail past an overflow is
	// seen outside a frame, and its closing '#' may open a new one
	task automatic send_long_frame();
		send_byte(DELIM_BYTE);
		send_byte("L");
		repeat ($urandom_range(32, 26))
			send_byte(($urandom_range(99) < 25) ? SEP_BYTE : pick_digit());
		send_byte(DELIM_BYTE);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// bytes outside a frame, lowest and highest value
	task automatic test_single_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// empty frame, comma as command, saturation, wrapped digits, and more
	// parameters than are kept
	task automatic test_special_frames();
		send_text("##");
		send_text("#,7#");
		send_text("#B,9,70000,1,");
		send_byte(8'hFF);
		send_text("0,5#");
	endtask

	// a frame of exactly the limit, one whose closing '#' is one too many,
	// and a single byte after the error
	task automatic test_frame_length();
		send_text("#L");
		repeat (9)
			send_text(",12");
		send_byte(DELIM_BYTE);
		send_text("#L");
		repeat (28)
			send_byte("1");
		send_byte(DELIM_BYTE);
		send_byte("x");
	endtask

	// mostly well-formed frames, plus noise, long frames and broken frames;
	// a calm stretch first, then idling on both sides
	task automatic test_random_traffic();
		int start;
		int pick;
		start = bytes_sent;
		gaps_on = 1'b0;
		while (bytes_sent < start + RANDOM_BYTES) begin
			if (bytes_sent >= start + CALM_BYTES)
				gaps_on = 1'b1;
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_random_frame();
			end else if (pick < 75) begin
				repeat ($urandom_range(4, 1))
					send_byte(8'($urandom_range(255, 0)));
			end else if (pick < 85) begin
				send_long_frame();
			end else begin
				// opened frame with random bytes and no proper close
				send_byte(DELIM_BYTE);
				repeat ($urandom_range(6, 1))
					send_byte(8'($urandom_range(255, 0)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		gaps_on = 1'b1;
		mismatch_cnt = 0;
		bytes_sent = 0;
		stall_cycles = 0;
		in_frm = 1'b0;
		frm_len = 0;
		clear_frame();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_single_bytes();
		test_special_frames();
		test_frame_length();
		test_random_traffic();

		// stop sending, let every owed result come out, then settle
		rx_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
